// ----- hw/rtl/eia3_mac_accumulator_unit_defines.svh -----
// Assertion macros for the EIA3 MAC accumulator.
// Included by the top level only; no other dependencies.
`ifndef EIA3_MAC_ACCUMULATOR_UNIT_DEFINES_SVH
`define EIA3_MAC_ACCUMULATOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define EIA3MAC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset
`define EIA3MAC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/eia3mac_pkg.sv -----
// Shared types and constants for the EIA3 MAC accumulator.
// No dependencies.
package eia3mac_pkg;

   localparam int WORD_W = 32;
   localparam int BITS_W = 6;
   localparam int OFS_W  = 5;

   // one accepted input word
   typedef struct packed {
      logic [WORD_W-1:0] keystream_word;
      logic [WORD_W-1:0] message_word;
      logic [BITS_W-1:0] message_bits;
      logic              last_key;
   } req_word_type;

   // end-of-message window control handed to the fold unit
   typedef struct packed {
      logic             end_pending;
      logic [OFS_W-1:0] end_offset;
   } fold_ctrl_type;

endpackage

// ----- hw/rtl/eia3mac_if.sv -----
// Valid/ready channel interfaces for request and response words.
// Depends on eia3mac_pkg.
interface eia3mac_req_if;
   logic                              valid;
   logic                              ready;
   logic [eia3mac_pkg::WORD_W-1:0]    keystream_word;
   logic [eia3mac_pkg::WORD_W-1:0]    message_word;
   logic [eia3mac_pkg::BITS_W-1:0]    message_bits;
   logic                              last_key;

   modport source (output valid, keystream_word, message_word, message_bits, last_key,
                   input ready);
   modport sink   (input valid, keystream_word, message_word, message_bits, last_key,
                   output ready);
endinterface

interface eia3mac_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [eia3mac_pkg::WORD_W-1:0]    tag;

   modport source (output valid, tag, input ready);
   modport sink   (input valid, tag, output ready);
endinterface

// ----- hw/rtl/eia3mac_fold.sv -----
// Window fold: XOR of keystream windows selected by a masked message word,
// plus the end-of-message window. Depends on eia3mac_pkg.
module eia3mac_fold (
   input  logic [eia3mac_pkg::WORD_W-1:0] pend_msg,
   input  logic [eia3mac_pkg::WORD_W-1:0] prev_key,
   input  logic [eia3mac_pkg::WORD_W-1:0] cur_key,
   input  eia3mac_pkg::fold_ctrl_type     ctrl,
   output logic [eia3mac_pkg::WORD_W-1:0] fold
);
   localparam int W = eia3mac_pkg::WORD_W;

   logic [2*W-1:0] cat;
   logic [2*W-1:0] cat_shift;
   logic [W-1:0]   terms [W];
   logic [W-1:0]   msg_fold;
   logic [W-1:0]   end_win;

   assign cat = {prev_key, cur_key};

   // one window per message bit, gated by that bit
   always_comb begin
      for (int j = 0; j < W; j++) begin
         terms[j] = cat[2*W-1-j -: W] & {W{pend_msg[W-1-j]}};
      end
   end

   // per-bit XOR reduction over all windows
   always_comb begin
      msg_fold = '0;
      for (int j = 0; j < W; j++) begin
         msg_fold = msg_fold ^ terms[j];
      end
   end

   // window at the message end
   assign cat_shift = cat << ctrl.end_offset;
   assign end_win   = ctrl.end_pending ? cat_shift[2*W-1:W] : '0;

   assign fold = msg_fold ^ end_win;
endmodule

// ----- hw/rtl/eia3_mac_accumulator_unit.sv -----
// Top level of the EIA3 MAC accumulator: input register, fold stage, tag register.
// Depends on eia3mac_pkg, eia3mac_if, eia3mac_fold and the defines header.
//
//   channel   dir  payload                                          handshake
//   req_chan  in   keystream_word, message_word, message_bits, last valid/ready
//   rsp_chan  out  tag                                              valid/ready
//
// One word per cycle unless a last word waits on an unread tag; the tag is registered after the input register.
// The input register feeds one fold stage that updates the accumulator state.
// A last word waits in the input register only while a previous tag is unread.
// Reset is synchronous and clears all control state, not the payload registers; the first word may follow at once.
`include "eia3_mac_accumulator_unit_defines.svh"

module eia3_mac_accumulator_unit (
   input logic                clock,
   input logic                reset,
   eia3mac_req_if.sink        req_chan,
   eia3mac_rsp_if.source      rsp_chan
);
   localparam int W = eia3mac_pkg::WORD_W;

   // input register
   logic                      s1_valid_ff, s1_valid_in;
   eia3mac_pkg::req_word_type s1_word_ff,  s1_word_in;
   logic                      s1_adv;
   logic                      req_take;

   // accumulator state
   logic [W-1:0]                  prev_key_ff,    prev_key_in;
   logic [W-1:0]                  accum_ff,       accum_in;
   logic [W-1:0]                  pend_msg_ff,    pend_msg_in;
   logic                          end_seen_ff,    end_seen_in;
   logic                          end_pending_ff, end_pending_in;
   logic [eia3mac_pkg::OFS_W-1:0] end_offset_ff,  end_offset_in;

   // result register
   logic         rsp_valid_ff, rsp_valid_in;
   logic [W-1:0] tag_ff,       tag_in;

   logic [W-1:0]               fold;
   logic [W-1:0]               acc_next;
   logic [W-1:0]               msg_mask;
   eia3mac_pkg::fold_ctrl_type fctrl;

   // stage advance: a non-last word never needs the result slot
   assign s1_adv   = s1_valid_ff &&
                     (!s1_word_ff.last_key || !rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_adv;
   assign req_take = req_chan.valid && req_chan.ready;

   always_comb begin
      s1_valid_in = req_take ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
      s1_word_in  = s1_word_ff;
      if (req_take) begin
         s1_word_in.keystream_word = req_chan.keystream_word;
         s1_word_in.message_word   = req_chan.message_word;
         s1_word_in.message_bits   = req_chan.message_bits;
         s1_word_in.last_key       = req_chan.last_key;
      end
   end

   // fold of the pending word and end window against prev/current keystream
   assign fctrl.end_pending = end_pending_ff;
   assign fctrl.end_offset  = end_offset_ff;

   eia3mac_fold u_fold (
      .pend_msg (pend_msg_ff),
      .prev_key (prev_key_ff),
      .cur_key  (s1_word_ff.keystream_word),
      .ctrl     (fctrl),
      .fold     (fold)
   );

   assign acc_next = accum_ff ^ fold;

   // keep only the valid leading bits of the message word
   assign msg_mask = s1_word_ff.message_bits[eia3mac_pkg::BITS_W-1] ? '1 :
                     ~({W{1'b1}} >> s1_word_ff.message_bits[eia3mac_pkg::OFS_W-1:0]);

   // state update
   always_comb begin
      prev_key_in    = prev_key_ff;
      accum_in       = accum_ff;
      pend_msg_in    = pend_msg_ff;
      end_seen_in    = end_seen_ff;
      end_pending_in = end_pending_ff;
      end_offset_in  = end_offset_ff;
      if (s1_adv) begin
         prev_key_in    = s1_word_ff.keystream_word;
         accum_in       = acc_next;
         pend_msg_in    = '0;
         end_pending_in = 1'b0;
         if (!end_seen_ff) begin
            pend_msg_in = s1_word_ff.message_word & msg_mask;
            if (!s1_word_ff.message_bits[eia3mac_pkg::BITS_W-1]) begin
               end_seen_in    = 1'b1;
               end_pending_in = 1'b1;
               end_offset_in  = s1_word_ff.message_bits[eia3mac_pkg::OFS_W-1:0];
            end
         end
         if (s1_word_ff.last_key) begin
            prev_key_in    = '0;
            accum_in       = '0;
            pend_msg_in    = '0;
            end_seen_in    = 1'b0;
            end_pending_in = 1'b0;
            end_offset_in  = '0;
         end
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      tag_in       = tag_ff;
      if (s1_adv && s1_word_ff.last_key) begin
         rsp_valid_in = 1'b1;
         tag_in       = acc_next ^ s1_word_ff.keystream_word;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.tag   = tag_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         prev_key_ff    <= '0;
         accum_ff       <= '0;
         pend_msg_ff    <= '0;
         end_seen_ff    <= 1'b0;
         end_pending_ff <= 1'b0;
         end_offset_ff  <= '0;
      end else begin
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         prev_key_ff    <= prev_key_in;
         accum_ff       <= accum_in;
         pend_msg_ff    <= pend_msg_in;
         end_seen_ff    <= end_seen_in;
         end_pending_ff <= end_pending_in;
         end_offset_ff  <= end_offset_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_word_ff <= s1_word_in;
      tag_ff     <= tag_in;
   end

   // checks
   `EIA3MAC_ASSERT_NEXT(a_clear_after_last, s1_adv && s1_word_ff.last_key, accum_ff == '0 && !end_seen_ff && pend_msg_ff == '0, "state not cleared after last word")
   `EIA3MAC_ASSERT_NOW(a_end_implies_seen, end_pending_ff, end_seen_ff, "end window pending without end mark")
   `EIA3MAC_ASSERT_NOW(a_tag_from_last, $rose(rsp_valid_ff), $past(s1_adv && s1_word_ff.last_key), "tag raised without a last word")
   `EIA3MAC_ASSERT_NOW(a_no_tag_overrun, s1_adv && s1_word_ff.last_key && rsp_valid_ff, rsp_chan.ready, "unread tag overwritten")

endmodule

// ----- tb/sv/eia3_mac_accumulator_unit_tb.sv -----
// Self-checking testbench for the EIA3 MAC accumulator: random and directed messages
// against a behavioral tag predictor, with bursty input and a stalling response side.
// Depends on eia3mac_pkg, eia3mac_if and the eia3_mac_accumulator_unit RTL.
`timescale 1ns / 1ps

module eia3_mac_accumulator_unit_tb;

   localparam int WORD_W = eia3mac_pkg::WORD_W;
   localparam int BITS_W = eia3mac_pkg::BITS_W;
   localparam int OFS_W  = eia3mac_pkg::OFS_W;

   localparam int FULL_BITS = 32;
   localparam int HOLD_CYCLES = 400;
   localparam int HOLD_AFTER_TAGS = 40;
   localparam int TARGET_WORDS = 950;

   typedef struct {
      eia3mac_pkg::req_word_type word;
      bit                        wait_idle;   // hold this word back until no tag is outstanding
   } queued_word_type;

   logic clock;
   logic reset;

   eia3mac_req_if req_chan ();
   eia3mac_rsp_if rsp_chan ();

   eia3_mac_accumulator_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   queued_word_type    outgoing_words[$];
   logic [WORD_W-1:0]  expected_tags[$];

   // predictor state
   logic [WORD_W-1:0] mac_prev_key;
   logic [WORD_W-1:0] mac_accum;
   logic [WORD_W-1:0] mac_pend_msg;
   logic [BITS_W-1:0] mac_pend_cnt;
   logic              mac_have_pend;
   logic              mac_end_seen;
   logic [OFS_W-1:0]  mac_end_ofs;
   logic              mac_end_pend;

   int errors = 0;
   int words_sent = 0;
   int tags_seen = 0;
   int burst_left = 0;
   int gap_left = 0;
   int cycle_no = 0;
   int hold_left = 0;
   bit hold_done = 0;
   logic [WORD_W-1:0] want_tag;

   // clock and reset
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.keystream_word = '0;
      req_chan.message_word = '0;
      req_chan.message_bits = '0;
      req_chan.last_key = 1'b0;
      rsp_chan.ready = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   // 32-bit keystream window starting ofs bits into hi, spilling into lo
   function automatic logic [WORD_W-1:0] keystream_slice(logic [WORD_W-1:0] hi,
                                                         logic [WORD_W-1:0] lo,
                                                         logic [OFS_W-1:0] ofs);
      logic [2*WORD_W-1:0] pair;
      pair = {hi, lo} << ofs;
      return pair[2*WORD_W-1:WORD_W];
   endfunction

   task automatic clear_mac_state();
      mac_prev_key  = '0;
      mac_accum     = '0;
      mac_pend_msg  = '0;
      mac_pend_cnt  = '0;
      mac_have_pend = 1'b0;
      mac_end_seen  = 1'b0;
      mac_end_ofs   = '0;
      mac_end_pend  = 1'b0;
   endtask

   // fold one accepted word into the MAC; a last word queues the expected tag
   task automatic fold_word(input eia3mac_pkg::req_word_type w);
      int cnt;
      if (mac_have_pend) begin
         cnt = (mac_pend_cnt > FULL_BITS) ? FULL_BITS : int'(mac_pend_cnt);
         for (int j = 0; j < cnt; j++)
            if (mac_pend_msg[WORD_W-1-j])
               mac_accum ^= keystream_slice(mac_prev_key, w.keystream_word, OFS_W'(j));
         mac_have_pend = 1'b0;
      end
      if (mac_end_pend) begin
         mac_accum ^= keystream_slice(mac_prev_key, w.keystream_word, mac_end_ofs);
         mac_end_pend = 1'b0;
      end
      if (!mac_end_seen) begin
         mac_pend_msg = w.message_word;
         if (w.message_bits >= FULL_BITS) begin
            mac_pend_cnt  = BITS_W'(FULL_BITS);
            mac_have_pend = 1'b1;
         end else begin
            mac_pend_cnt  = w.message_bits;
            mac_have_pend = (w.message_bits != 0);
            mac_end_seen  = 1'b1;
            mac_end_ofs   = w.message_bits[OFS_W-1:0];
            mac_end_pend  = 1'b1;
         end
      end
      mac_prev_key = w.keystream_word;
      if (w.last_key) begin
         expected_tags.push_back(mac_accum ^ w.keystream_word);
         clear_mac_state();
      end
   endtask

   task automatic push_word(input logic [WORD_W-1:0] z, input logic [WORD_W-1:0] m,
                            input int bits, input bit last, input bit wait_idle = 0);
      queued_word_type q;
      q.word.keystream_word = z;
      q.word.message_word   = m;
      q.word.message_bits   = BITS_W'(bits);
      q.word.last_key       = last;
      q.wait_idle           = wait_idle;
      outgoing_words.push_back(q);
   endtask

   function automatic logic [WORD_W-1:0] rand_msg();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   // bit count of a non-final message word: mostly 32, sometimes an oversized count
   function automatic int full_bits();
      return ($urandom_range(0, 5) == 0) ? $urandom_range(33, 63) : FULL_BITS;
   endfunction

   // full words, then the end word, then trailing keystream words (last on the final one)
   task automatic push_message(input int nfull, input int end_bits, input int trailing,
                               input bit wait_idle);
      for (int i = 0; i < nfull; i++)
         push_word($urandom, rand_msg(), full_bits(), 1'b0, wait_idle && i == 0);
      push_word($urandom, rand_msg(), end_bits, trailing == 0, wait_idle && nfull == 0);
      for (int t = 0; t < trailing; t++)
         push_word($urandom, rand_msg(), $urandom_range(0, 63), t == trailing - 1);
   endtask

   // stimulus
   initial begin
      int sel;
      int msg_idx;
      int len;
      clear_mac_state();

      // empty message, then a single last word straight out of idle
      push_word('0, '1, 0, 1'b0);
      push_word('1, '1, 0, 1'b1);
      push_word(32'hDEADBEEF, 32'h8000_0001, FULL_BITS, 1'b1);
      // all-ones message over a full word and 31 bits of the next
      push_word('1, '1, FULL_BITS, 1'b0);
      push_word(32'h8000_0000, '1, 31, 1'b0);
      push_word(32'h0000_0001, '0, 0, 1'b1);
      // oversized bit count counts as a full word
      push_word(32'h1234_5678, 32'hA5A5_A5A5, 63, 1'b0);
      push_word(32'h9ABC_DEF0, 32'h8000_0000, 1, 1'b0);
      push_word(32'h0F0F_0F0F, 32'h0000_0001, 33, 1'b1);
      // last word carries the end mark itself
      push_word(32'hCAFE_F00D, 32'hF800_0000, 5, 1'b1);
      // last word before any end mark
      push_word(32'h0000_0001, 32'h0000_0001, FULL_BITS, 1'b0);
      push_word(32'h8000_0000, '1, FULL_BITS, 1'b1);
      // words after the end carry garbage that must be ignored
      push_word(32'h1111_1111, 32'hFFFF_0000, 16, 1'b0);
      push_word(32'h2222_2222, '1, 40, 1'b0);
      push_word(32'h4444_4444, '1, 7, 1'b0);
      push_word(32'h8888_8888, '1, 63, 1'b1, 1'b1);
      // zero keystream, zero message, single-bit end
      push_word('0, '0, FULL_BITS, 1'b0);
      push_word('0, '0, 1, 1'b0);
      push_word('0, '0, 0, 1'b1);
      push_word('1, 32'h0000_0001, 32, 1'b0);
      push_word('1, 32'h0000_0001, 31, 1'b0);
      push_word('1, '0, 0, 1'b0);
      push_word('1, '0, 0, 1'b1);

      // random messages, mostly well formed
      msg_idx = 0;
      while (outgoing_words.size() < TARGET_WORDS) begin
         sel = $urandom_range(0, 9);
         if (sel < 8) begin
            push_message(($urandom_range(0, 7) == 0) ? $urandom_range(5, 12)
                                                     : $urandom_range(0, 4),
                         $urandom_range(0, 31),
                         ($urandom_range(0, 5) == 0) ? $urandom_range(0, 3) : 1,
                         msg_idx == 25 || $urandom_range(0, 49) == 0);
         end else begin
            // broken: random words of any bit count, last wherever it falls
            len = $urandom_range(1, 6);
            for (int k = 0; k < len; k++)
               push_word($urandom, rand_msg(), $urandom_range(0, 63), k == len - 1);
         end
         msg_idx++;
      end

      // drain
      @(posedge clock);
      while (outgoing_words.size() != 0 || expected_tags.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Covered %0d words in %0d messages, %0d tags checked,", words_sent,
               msg_idx, tags_seen);
      $display("with bursty input, response stalls and a %0d-cycle response hold-off.",
               HOLD_CYCLES);
      if (errors == 0) begin
         $display("PASS eia3_mac_accumulator_unit");
      end else begin
         $display("FAIL eia3_mac_accumulator_unit");
      end
      $finish;
   end

   // request driver: bursts with random gaps, optional wait for idle
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         burst_left = $urandom_range(1, 40);
         gap_left = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            fold_word(outgoing_words[0].word);
            outgoing_words.delete(0);
            words_sent++;
         end
         if (req_chan.valid && !req_chan.ready) begin
            // word still on offer, keep it stable
         end else if (outgoing_words.size() == 0) begin
            req_chan.valid <= 1'b0;
         end else if (gap_left > 0) begin
            gap_left--;
            req_chan.valid <= 1'b0;
         end else if (outgoing_words[0].wait_idle && expected_tags.size() != 0) begin
            req_chan.valid <= 1'b0;
         end else begin
            req_chan.valid          <= 1'b1;
            req_chan.keystream_word <= outgoing_words[0].word.keystream_word;
            req_chan.message_word   <= outgoing_words[0].word.message_word;
            req_chan.message_bits   <= outgoing_words[0].word.message_bits;
            req_chan.last_key       <= outgoing_words[0].word.last_key;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
      end
   end

   // response monitor and ready pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         cycle_no = 0;
         hold_left = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            tags_seen++;
            if (expected_tags.size() == 0) begin
               $error("tag: expected none, actual %h", rsp_chan.tag);
               errors++;
            end else begin
               want_tag = expected_tags.pop_front();
               if (rsp_chan.tag !== want_tag) begin
                  $error("tag mismatch: expected %h, actual %h", want_tag, rsp_chan.tag);
                  errors++;
               end
            end
         end
         cycle_no++;
         // one long hold-off so the input side backs up
         if (!hold_done && tags_seen >= HOLD_AFTER_TAGS) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            case ((cycle_no / 64) % 4)
               0: rsp_chan.ready <= 1'b1;
               1: rsp_chan.ready <= $urandom_range(0, 1);
               2: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_chan.ready <= cycle_no[0];
            endcase
         end
      end
   end

   // watchdog
   initial begin
      #5ms;
      $display("FAIL eia3_mac_accumulator_unit");
      $finish;
   end

endmodule
